// ===== sv/rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared types and constants for the radial brush falloff weight core.
// ----------------------------------------------------------------------------
package rbf_pkg;

  localparam int CoordW   = 16;
  localparam int DiffW    = CoordW + 1;
  localparam int SqW      = 2 * CoordW;
  localparam int D2W      = SqW + 1;
  localparam int TrialW   = SqW + 1;
  localparam int RootW    = CoordW;
  localparam int MagW     = 15;
  localparam int ProdW    = MagW + CoordW;
  localparam int QuotW    = MagW;
  localparam int CfgIdxW  = 3;

  localparam int MidDepth = 4;
  localparam int MidPtrW  = 2;
  localparam int MidCntW  = 3;

  localparam int OutDepth = 2;
  localparam int OutPtrW  = 1;
  localparam int OutCntW  = 2;

  localparam logic signed [CoordW-1:0] HardMax = 16'sd16384;
  localparam logic signed [CoordW-1:0] HardMin = -16'sd16384;

  localparam logic signed [CoordW-1:0] ResetCenterX = 16'sd0;
  localparam logic signed [CoordW-1:0] ResetCenterY = 16'sd0;
  localparam logic [CoordW-1:0]        ResetInner   = 16'd80;
  localparam logic [CoordW-1:0]        ResetOuter   = 16'd160;
  localparam logic signed [CoordW-1:0] ResetHard    = 16'sd16384;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_INNER_RADIUS = 3'd2,
    REG_OUTER_RADIUS = 3'd3,
    REG_HARDNESS     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_CORE = 2'd1,
    CLS_RAMP = 2'd2
  } wclass_t;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic [CoordW-1:0]        inner_radius;
    logic [CoordW-1:0]        outer_radius;
    logic [SqW-1:0]           inner_sq;
    logic [SqW-1:0]           outer_sq;
    logic                     enable;
    logic [CoordW-1:0]        span;
    logic signed [CoordW-1:0] hard;
    logic [MagW-1:0]          hard_mag;
    logic                     hard_neg;
  } brush_cfg_t;

  typedef struct packed {
    wclass_t        cls;
    logic           hit;
    logic [SqW-1:0] d2;
  } mid_entry_t;

  typedef struct packed {
    logic signed [CoordW-1:0] weight;
    logic                     hit;
  } out_entry_t;

endpackage

// ===== sv/rbf_front.sv =====
// ----------------------------------------------------------------------------
// rbf_front
// Takes points, forms the squared distance and classifies core, ramp or zero.
// ----------------------------------------------------------------------------
module rbf_front
  import rbf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic                     advance,
  input  brush_cfg_t               cfg,
  input  logic signed [CoordW-1:0] point_x,
  input  logic signed [CoordW-1:0] point_y,
  output logic                     out_valid,
  output mid_entry_t               out_entry
);

  logic                    s1_valid;
  logic signed [DiffW-1:0] s1_dx;
  logic signed [DiffW-1:0] s1_dy;

  logic                    s2_valid;
  logic [SqW-1:0]          s2_sq_x;
  logic [SqW-1:0]          s2_sq_y;

  logic                    s3_valid;
  logic [D2W-1:0]          s3_d2;

  logic signed [2*DiffW-1:0] prod_x;
  logic signed [2*DiffW-1:0] prod_y;
  logic                      in_core;
  logic                      in_ramp;
  logic                      in_outer;

  assign prod_x = s1_dx * s1_dx;
  assign prod_y = s1_dy * s1_dy;

  assign in_core  = cfg.enable && (s3_d2 <= {1'b0, cfg.inner_sq});
  assign in_ramp  = cfg.enable && !in_core && (s3_d2 < {1'b0, cfg.outer_sq});
  assign in_outer = s3_d2 <= {1'b0, cfg.outer_sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= push;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_dx   <= {point_x[CoordW-1], point_x} - {cfg.center_x[CoordW-1], cfg.center_x};
      s1_dy   <= {point_y[CoordW-1], point_y} - {cfg.center_y[CoordW-1], cfg.center_y};
      s2_sq_x <= prod_x[SqW-1:0];
      s2_sq_y <= prod_y[SqW-1:0];
      s3_d2   <= {1'b0, s2_sq_x} + {1'b0, s2_sq_y};
      out_entry.d2  <= s3_d2[SqW-1:0];
      out_entry.hit <= in_outer;
      if (in_core) begin
        out_entry.cls <= CLS_CORE;
      end else if (in_ramp) begin
        out_entry.cls <= CLS_RAMP;
      end else begin
        out_entry.cls <= CLS_ZERO;
      end
    end
  end

endmodule

// ===== sv/rbf_mid_queue.sv =====
// ----------------------------------------------------------------------------
// rbf_mid_queue
// Short queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module rbf_mid_queue
  import rbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  mid_entry_t wr_entry,
  output logic       full,
  output logic       rd_valid,
  output mid_entry_t rd_entry,
  input  logic       rd_en
);

  mid_entry_t         mem [0:MidDepth-1];
  logic [MidPtrW-1:0] wr_ptr;
  logic [MidPtrW-1:0] rd_ptr;
  logic [MidCntW-1:0] count;

  assign full     = (count == MidCntW'(MidDepth));
  assign rd_valid = (count != '0);
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + MidPtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + MidPtrW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + MidCntW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - MidCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

endmodule

// ===== sv/rbf_back.sv =====
// ----------------------------------------------------------------------------
// rbf_back
// Square root, ramp product and divide pipelines, then the result queue.
// ----------------------------------------------------------------------------
module rbf_back
  import rbf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  brush_cfg_t               cfg,
  input  logic                     in_valid,
  input  mid_entry_t               in_entry,
  output logic                     in_pop,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [CoordW-1:0] weight,
  output logic                     inside_res
);

  typedef struct packed {
    logic             valid;
    wclass_t          cls;
    logic             hit;
    logic [SqW-1:0]   rem;
    logic [RootW-1:0] root;
  } sq_stage_t;

  typedef struct packed {
    logic             valid;
    wclass_t          cls;
    logic             hit;
    logic [RootW-1:0] diff;
  } df_stage_t;

  typedef struct packed {
    logic             valid;
    wclass_t          cls;
    logic             hit;
    logic [ProdW-1:0] rem;
    logic [QuotW-1:0] quot;
  } dv_stage_t;

  sq_stage_t sq [0:RootW];
  df_stage_t df;
  dv_stage_t dv [0:QuotW];

  out_entry_t         oq [0:OutDepth-1];
  logic [OutPtrW-1:0] oq_wr;
  logic [OutPtrW-1:0] oq_rd;
  logic [OutCntW-1:0] oq_count;

  logic                     advance;
  logic                     oq_push;
  logic                     oq_pop;
  logic [ProdW-1:0]         prod;
  logic signed [CoordW-1:0] weight_next;

  assign advance = (oq_count != OutCntW'(OutDepth));
  assign in_pop  = advance && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].valid <= 1'b0;
    end else if (advance) begin
      sq[0].valid <= in_valid;
      sq[0].cls   <= in_entry.cls;
      sq[0].hit   <= in_entry.hit;
      sq[0].rem   <= in_entry.d2;
      sq[0].root  <= '0;
    end
  end

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    localparam int Bit = RootW - 1 - k;
    logic [TrialW-1:0] trial;
    logic              take;

    assign trial = (TrialW'(sq[k].root) << (Bit + 1)) + (TrialW'(1) << (2 * Bit));
    assign take  = {1'b0, sq[k].rem} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq[k+1].valid <= 1'b0;
      end else if (advance) begin
        sq[k+1].valid <= sq[k].valid;
        sq[k+1].cls   <= sq[k].cls;
        sq[k+1].hit   <= sq[k].hit;
        if (take) begin
          sq[k+1].rem  <= sq[k].rem - trial[SqW-1:0];
          sq[k+1].root <= sq[k].root | (RootW'(1) << Bit);
        end else begin
          sq[k+1].rem  <= sq[k].rem;
          sq[k+1].root <= sq[k].root;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      df.valid <= 1'b0;
    end else if (advance) begin
      df.valid <= sq[RootW].valid;
      df.cls   <= sq[RootW].cls;
      df.hit   <= sq[RootW].hit;
      df.diff  <= cfg.outer_radius - sq[RootW].root;
    end
  end

  assign prod = ProdW'(cfg.hard_mag) * ProdW'(df.diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (advance) begin
      dv[0].valid <= df.valid;
      dv[0].cls   <= df.cls;
      dv[0].hit   <= df.hit;
      dv[0].rem   <= prod;
      dv[0].quot  <= '0;
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_div
    localparam int Bit = QuotW - 1 - k;
    logic [ProdW-1:0] dsor;
    logic             take;

    assign dsor = ProdW'(cfg.span) << Bit;
    assign take = dv[k].rem >= dsor;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1].valid <= 1'b0;
      end else if (advance) begin
        dv[k+1].valid <= dv[k].valid;
        dv[k+1].cls   <= dv[k].cls;
        dv[k+1].hit   <= dv[k].hit;
        if (take) begin
          dv[k+1].rem  <= dv[k].rem - dsor;
          dv[k+1].quot <= dv[k].quot | (QuotW'(1) << Bit);
        end else begin
          dv[k+1].rem  <= dv[k].rem;
          dv[k+1].quot <= dv[k].quot;
        end
      end
    end
  end

  always_comb begin
    unique case (dv[QuotW].cls)
      CLS_CORE: weight_next = cfg.hard;
      CLS_RAMP: begin
        if (cfg.hard_neg) begin
          weight_next = -$signed({1'b0, dv[QuotW].quot});
        end else begin
          weight_next = $signed({1'b0, dv[QuotW].quot});
        end
      end
      default: weight_next = '0;
    endcase
  end

  assign oq_push    = advance && dv[QuotW].valid;
  assign empty      = (oq_count == '0);
  assign oq_pop     = pop && !empty;
  assign weight     = oq[oq_rd].weight;
  assign inside_res = oq[oq_rd].hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (oq_push) begin
        oq_wr <= oq_wr + OutPtrW'(1);
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + OutPtrW'(1);
      end
      if (oq_push && !oq_pop) begin
        oq_count <= oq_count + OutCntW'(1);
      end else if (oq_pop && !oq_push) begin
        oq_count <= oq_count - OutCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wr].weight <= weight_next;
      oq[oq_wr].hit    <= dv[QuotW].hit;
    end
  end

endmodule

// ===== sv/radial_brush_falloff_weight_core.sv =====
// Throughput: one point per cycle, set by the one-bit-per-stage square root
// and divide pipelines; any stall holds the whole back pipeline at once.
// Reset clears the queues and pipeline valids and loads the register defaults;
// a configuration write lands in its register and is then copied into the
// registered brush configuration before it takes effect.
// ----------------------------------------------------------------------------
// radial_brush_falloff_weight_core
// Soft radial brush weight with linear falloff between inner and outer radius.
// ----------------------------------------------------------------------------
module radial_brush_falloff_weight_core
  import rbf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic signed [CoordW-1:0] point_x,
  input  logic signed [CoordW-1:0] point_y,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [CoordW-1:0] weight,
  output logic                     inside_res,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CoordW-1:0]        cfg_data
);

  logic signed [CoordW-1:0] center_x;
  logic signed [CoordW-1:0] center_y;
  logic [CoordW-1:0]        inner_radius;
  logic [CoordW-1:0]        outer_radius;
  logic signed [CoordW-1:0] hardness;

  logic signed [CoordW-1:0] hard_clamp;
  brush_cfg_t               cfg;

  logic       front_valid;
  mid_entry_t front_entry;
  logic       mq_full;
  logic       mq_valid;
  mid_entry_t mq_entry;
  logic       mq_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= ResetCenterX;
      center_y     <= ResetCenterY;
      inner_radius <= ResetInner;
      outer_radius <= ResetOuter;
      hardness     <= ResetHard;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:     center_x     <= cfg_data;
        REG_CENTER_Y:     center_y     <= cfg_data;
        REG_INNER_RADIUS: inner_radius <= cfg_data;
        REG_OUTER_RADIUS: outer_radius <= cfg_data;
        REG_HARDNESS:     hardness     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (hardness > HardMax) begin
      hard_clamp = HardMax;
    end else if (hardness < HardMin) begin
      hard_clamp = HardMin;
    end else begin
      hard_clamp = hardness;
    end
  end

  always_ff @(posedge clk) begin
    cfg.center_x     <= center_x;
    cfg.center_y     <= center_y;
    cfg.inner_radius <= inner_radius;
    cfg.outer_radius <= outer_radius;
    cfg.inner_sq     <= SqW'(inner_radius) * SqW'(inner_radius);
    cfg.outer_sq     <= SqW'(outer_radius) * SqW'(outer_radius);
    cfg.enable       <= inner_radius <= outer_radius;
    cfg.span         <= outer_radius - inner_radius;
    cfg.hard         <= hard_clamp;
    cfg.hard_neg     <= hard_clamp[CoordW-1];
    if (hard_clamp[CoordW-1]) begin
      cfg.hard_mag <= MagW'(-hard_clamp);
    end else begin
      cfg.hard_mag <= MagW'(hard_clamp);
    end
  end

  assign full = mq_full;

  rbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .advance   (!mq_full),
    .cfg       (cfg),
    .point_x   (point_x),
    .point_y   (point_y),
    .out_valid (front_valid),
    .out_entry (front_entry)
  );

  rbf_mid_queue u_mid_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (front_valid && !mq_full),
    .wr_entry (front_entry),
    .full     (mq_full),
    .rd_valid (mq_valid),
    .rd_entry (mq_entry),
    .rd_en    (mq_pop)
  );

  rbf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (mq_valid),
    .in_entry   (mq_entry),
    .in_pop     (mq_pop),
    .empty      (empty),
    .pop        (pop),
    .weight     (weight),
    .inside_res (inside_res)
  );

endmodule
